### rtl/core/cooker_mode_and_thermal_control_unit_assert.svh
// ----------------------------------------------------------------------------
// Cooker control assertion macros
// Shorthand for the clocked checks used in the cooker control unit.
// ----------------------------------------------------------------------------
`ifndef COOKER_MODE_AND_THERMAL_CONTROL_UNIT_ASSERT_SVH
`define COOKER_MODE_AND_THERMAL_CONTROL_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CMTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define CMTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/cmtc_pkg.sv
// ----------------------------------------------------------------------------
// Cooker control package
// Types, register indexes and constants shared by the cooker control unit.
// ----------------------------------------------------------------------------
package cmtc_pkg;

	// operating modes
	typedef enum logic [1:0] {
		MODE_SET_TEMP = 2'd0,
		MODE_SET_TIME = 2'd1,
		MODE_COOKING  = 2'd2,
		MODE_DONE     = 2'd3
	} mode_t;

	// buzzer codes
	typedef enum logic [1:0] {
		BEEP_NONE   = 2'd0,
		BEEP_SHORT  = 2'd1,
		BEEP_MEDIUM = 2'd2,
		BEEP_LONG   = 2'd3
	} beep_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_HEATER_BAND     = 3'd0,
		REG_FAN_ON_TEMP     = 3'd1,
		REG_FAN_BAND        = 3'd2,
		REG_DEFAULT_TEMP    = 3'd3,
		REG_DEFAULT_MINUTES = 3'd4,
		REG_MAX_TEMP        = 3'd5,
		REG_MAX_MINUTES     = 3'd6
	} cfg_idx_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 9;
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 48;

	localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
	localparam logic [22:0] TIMER_MAX     = 23'h7FFFFF;

	// reset values
	localparam logic [5:0]  RST_HEATER_BAND     = 6'd10;
	localparam logic [8:0]  RST_FAN_ON_TEMP     = 9'd80;
	localparam logic [5:0]  RST_FAN_BAND        = 6'd5;
	localparam logic [7:0]  RST_DEFAULT_TEMP    = 8'd180;
	localparam logic [6:0]  RST_DEFAULT_MINUTES = 7'd30;
	localparam logic [7:0]  RST_MAX_TEMP        = 8'd250;
	localparam logic [6:0]  RST_MAX_MINUTES     = 7'd120;
	localparam logic [11:0] RST_COUNT           = 12'd180;
	localparam logic [7:0]  RST_TARGET          = 8'd180;
	localparam logic [6:0]  RST_MINUTES         = 7'd30;

	typedef struct packed {
		logic [5:0] heater_band;
		logic [8:0] fan_on_temp;
		logic [5:0] fan_band;
		logic [7:0] default_temp;
		logic [6:0] default_minutes;
		logic [7:0] max_temp;
		logic [6:0] max_minutes;
	} cfg_t;

	// one input word, temperature and encoder_delta are two's complement
	typedef struct packed {
		logic [9:0] elapsed_ms;
		logic       button_down;
		logic [3:0] encoder_delta;
		logic [9:0] temperature;
	} item_t;

	// mode controller state
	typedef struct packed {
		mode_t       mode;
		logic [11:0] count;
		logic [7:0]  target;
		logic [6:0]  minutes;
		logic [22:0] timer;
		logic        flip_done;
	} ctl_t;

	typedef struct packed {
		logic        flip_alert;
		beep_t       beep_code;
		logic [22:0] cook_elapsed;
		logic [6:0]  cook_minutes;
		logic [7:0]  temp_setpoint;
		logic        fan_on;
		logic        heater_on;
		mode_t       mode;
	} result_t;

endpackage

### rtl/core/cooker_mode_and_thermal_control_unit.sv
// Cooker mode and thermal control unit. Takes one sample word per clock and
// gives one result word for each, via the input and result registers; the
// sustained rate is one word per clock as long as the result side takes
// words. Each word passes once through the relay and mode logic, where the
// timer add and the compare against the cook duration set the longest path.
// Presses are rising edges of button_down from one word to the next.
// Settings must be written on the cfg port while no word is in flight; the
// block does not enforce this. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
// Cooker mode and thermal control unit
// Stream wrapper with input register, step logic and result register.
// ----------------------------------------------------------------------------
module cooker_mode_and_thermal_control_unit
	import cmtc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// sample words
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// temperature[9:0], encoder_delta[13:10], button_down[14],
	// elapsed_ms[24:15], zeros[31:25]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// result words
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// mode[1:0], heater_on[2], fan_on[3], temp_setpoint[11:4],
	// cook_minutes[18:12], cook_elapsed[41:19], beep_code[43:42],
	// flip_alert[44], zeros[47:45]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	`include "cooker_mode_and_thermal_control_unit_assert.svh"

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	ctl_t    ctl_q;
	ctl_t    ctl_d;
	logic    heater_q;
	logic    fan_q;
	logic    held_q;
	logic    heater_d;
	logic    fan_d;
	logic    press;
	logic    advance;
	logic    s_accept;
	beep_t   beep;
	logic    flip;

	cmtc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// handshake, the input stage moves whenever the result slot frees up
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= item_t'(s_tdata[24:0]);
		end
	end

	assign press = item_s1.button_down && !held_q;

	cmtc_relay u_relay (
		.mode        (ctl_q.mode),
		.temperature (item_s1.temperature),
		.target      (ctl_q.target),
		.heater_q    (heater_q),
		.fan_q       (fan_q),
		.cfg         (cfg),
		.heater_d    (heater_d),
		.fan_d       (fan_d)
	);

	cmtc_mode u_mode (
		.ctl_q         (ctl_q),
		.encoder_delta (item_s1.encoder_delta),
		.press         (press),
		.elapsed_ms    (item_s1.elapsed_ms),
		.cfg           (cfg),
		.ctl_d         (ctl_d),
		.beep          (beep),
		.flip          (flip)
	);

	// controller state, updated once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.mode      <= MODE_SET_TEMP;
			ctl_q.count     <= RST_COUNT;
			ctl_q.target    <= RST_TARGET;
			ctl_q.minutes   <= RST_MINUTES;
			ctl_q.timer     <= '0;
			ctl_q.flip_done <= 1'b0;
			heater_q        <= 1'b0;
			fan_q           <= 1'b0;
			held_q          <= 1'b0;
		end else if (advance) begin
			ctl_q    <= ctl_d;
			heater_q <= heater_d;
			fan_q    <= fan_d;
			held_q   <= item_s1.button_down;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.mode          <= ctl_d.mode;
			res_s2.heater_on     <= heater_d;
			res_s2.fan_on        <= fan_d;
			res_s2.temp_setpoint <= ctl_d.target;
			res_s2.cook_minutes  <= ctl_d.minutes;
			res_s2.cook_elapsed  <= ctl_d.timer;
			res_s2.beep_code     <= beep;
			res_s2.flip_alert    <= flip;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b0, res_s2};

	// checks
	`CMTC_ASSERT_NOW(a_heater_needs_fan, valid_s2 && res_s2.heater_on, res_s2.fan_on,
		"heater on with fan off")
	`CMTC_ASSERT_NOW(a_flip_beeps, valid_s2 && res_s2.flip_alert,
		res_s2.beep_code == BEEP_MEDIUM || res_s2.beep_code == BEEP_LONG,
		"flip alert without beep")
	`CMTC_ASSERT_NEXT(a_done_holds, advance && ctl_q.mode == MODE_DONE && !press,
		ctl_q.mode == MODE_DONE, "done mode left without a press")
	`CMTC_ASSERT_NEXT(a_s1_kept, valid_s1 && !advance, valid_s1,
		"stalled input word dropped")

endmodule

### rtl/core/cmtc_cfg.sv
// ----------------------------------------------------------------------------
// Cooker control configuration registers
// Holds the seven settings, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module cmtc_cfg
	import cmtc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register bank, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heater_band     <= RST_HEATER_BAND;
			cfg_q.fan_on_temp     <= RST_FAN_ON_TEMP;
			cfg_q.fan_band        <= RST_FAN_BAND;
			cfg_q.default_temp    <= RST_DEFAULT_TEMP;
			cfg_q.default_minutes <= RST_DEFAULT_MINUTES;
			cfg_q.max_temp        <= RST_MAX_TEMP;
			cfg_q.max_minutes     <= RST_MAX_MINUTES;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEATER_BAND:     cfg_q.heater_band     <= cfg_wdata[5:0];
				REG_FAN_ON_TEMP:     cfg_q.fan_on_temp     <= cfg_wdata[8:0];
				REG_FAN_BAND:        cfg_q.fan_band        <= cfg_wdata[5:0];
				REG_DEFAULT_TEMP:    cfg_q.default_temp    <= cfg_wdata[7:0];
				REG_DEFAULT_MINUTES: cfg_q.default_minutes <= cfg_wdata[6:0];
				REG_MAX_TEMP:        cfg_q.max_temp        <= cfg_wdata[7:0];
				REG_MAX_MINUTES:     cfg_q.max_minutes     <= cfg_wdata[6:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/cmtc_relay.sv
// ----------------------------------------------------------------------------
// Cooker control relay logic
// Heater and fan hysteresis, driven from the mode held before the word.
// ----------------------------------------------------------------------------
module cmtc_relay
	import cmtc_pkg::*;
(
	input  mode_t      mode,
	input  logic [9:0] temperature,
	input  logic [7:0] target,
	input  logic       heater_q,
	input  logic       fan_q,
	input  cfg_t       cfg,
	output logic       heater_d,
	output logic       fan_d
);

	logic signed [10:0] temp_w;
	logic signed [10:0] heat_lo;
	logic signed [10:0] heat_hi;
	logic signed [10:0] fan_hi;
	logic signed [10:0] fan_lo;

	// thresholds in eleven bit signed
	always_comb begin
		temp_w  = $signed({temperature[9], temperature});
		heat_lo = $signed({3'b0, target}) - $signed({5'b0, cfg.heater_band});
		heat_hi = $signed({3'b0, target}) + $signed({5'b0, cfg.heater_band});
		fan_hi  = $signed({2'b0, cfg.fan_on_temp});
		fan_lo  = $signed({2'b0, cfg.fan_on_temp}) - $signed({5'b0, cfg.fan_band});
	end

	// hysteresis, holding between the two thresholds
	always_comb begin
		heater_d = heater_q;
		fan_d    = fan_q;
		if (mode == MODE_COOKING) begin
			fan_d = 1'b1;
			if (temp_w <= heat_lo) begin
				heater_d = 1'b1;
			end else if (temp_w >= heat_hi) begin
				heater_d = 1'b0;
			end
		end else begin
			heater_d = 1'b0;
			if (temp_w >= fan_hi) begin
				fan_d = 1'b1;
			end else if (temp_w <= fan_lo) begin
				fan_d = 1'b0;
			end
		end
	end

endmodule

### rtl/core/cmtc_mode.sv
// ----------------------------------------------------------------------------
// Cooker control mode logic
// Encoder count, settings, cook timer, flip alert and beep codes per word.
// ----------------------------------------------------------------------------
module cmtc_mode
	import cmtc_pkg::*;
(
	input  ctl_t       ctl_q,
	input  logic [3:0] encoder_delta,
	input  logic       press,
	input  logic [9:0] elapsed_ms,
	input  cfg_t       cfg,
	output ctl_t       ctl_d,
	output beep_t      beep,
	output logic       flip
);

	logic signed [12:0] sum13;
	logic signed [11:0] cnt_sat;
	logic signed [11:0] cnt_temp;
	logic signed [11:0] cnt_min1;
	logic signed [11:0] cnt_time;
	logic [23:0]        tsum;
	logic [22:0]        timer_n;
	logic [22:0]        total;
	logic [22:0]        half;

	// encoder count with saturation at the twelve bit limits
	always_comb begin
		sum13 = $signed({ctl_q.count[11], ctl_q.count})
			+ $signed({{9{encoder_delta[3]}}, encoder_delta});
		if (sum13[12] != sum13[11]) begin
			cnt_sat = sum13[12] ? 12'sh800 : 12'sh7FF;
		end else begin
			cnt_sat = sum13[11:0];
		end
	end

	// clamps for the two setting modes
	always_comb begin
		if (cnt_sat[11]) begin
			cnt_temp = '0;
		end else if (cnt_sat > $signed({4'b0, cfg.max_temp})) begin
			cnt_temp = $signed({4'b0, cfg.max_temp});
		end else begin
			cnt_temp = cnt_sat;
		end
		cnt_min1 = (cnt_sat < 12'sd1) ? 12'sd1 : cnt_sat;
		if (cnt_min1 > $signed({5'b0, cfg.max_minutes})) begin
			cnt_time = $signed({5'b0, cfg.max_minutes});
		end else begin
			cnt_time = cnt_min1;
		end
	end

	// cook timer and durations
	always_comb begin
		tsum    = {1'b0, ctl_q.timer} + {14'b0, elapsed_ms};
		timer_n = tsum[23] ? TIMER_MAX : tsum[22:0];
		total   = {16'b0, ctl_q.minutes} * {7'b0, MS_PER_MINUTE};
		half    = total >> 1;
	end

	// mode sequencing
	always_comb begin
		ctl_d   = ctl_q;
		ctl_d.count = cnt_sat;
		beep    = BEEP_NONE;
		flip    = 1'b0;
		unique case (ctl_q.mode)
			MODE_SET_TEMP: begin
				ctl_d.count  = cnt_temp;
				ctl_d.target = cnt_temp[7:0];
				if (press) begin
					beep        = BEEP_SHORT;
					ctl_d.mode  = MODE_SET_TIME;
					ctl_d.count = {5'b0, cfg.default_minutes};
				end
			end
			MODE_SET_TIME: begin
				ctl_d.count   = cnt_time;
				ctl_d.minutes = cnt_time[6:0];
				if (press) begin
					beep            = BEEP_MEDIUM;
					ctl_d.timer     = '0;
					ctl_d.flip_done = 1'b0;
					ctl_d.mode      = MODE_COOKING;
				end
			end
			MODE_COOKING: begin
				ctl_d.timer = timer_n;
				if (!ctl_q.flip_done && (timer_n > half)) begin
					flip            = 1'b1;
					ctl_d.flip_done = 1'b1;
					beep            = BEEP_MEDIUM;
				end
				if (timer_n >= total) begin
					beep       = BEEP_LONG;
					ctl_d.mode = MODE_DONE;
				end
				if (press) begin
					ctl_d.mode  = MODE_SET_TEMP;
					ctl_d.count = {4'b0, ctl_q.target};
				end
			end
			MODE_DONE: begin
				if (press) begin
					ctl_d.mode  = MODE_SET_TEMP;
					ctl_d.count = {4'b0, cfg.default_temp};
				end
			end
			default: begin
			end
		endcase
	end

endmodule
